FILE: rtl/core/k_smallest_sum_pairs_macros.svh
// Assertion macros used by the k smallest sum pairs checker.
// No dependencies; clock and reset names are passed in at each use.
`ifndef K_SMALLEST_SUM_PAIRS_MACROS_SVH
`define K_SMALLEST_SUM_PAIRS_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define KSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/ksp_pkg.sv
// Types, sizes and codes for the k smallest sum pairs block.
// Used by the controller, the datapath, the top level and the checker.
package ksp_pkg;

    localparam int FIRST_DEPTH  = 64;
    localparam int SECOND_DEPTH = 64;
    localparam int MAX_PAIRS    = 64;

    localparam int FA_W  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
    localparam int SA_W  = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
    localparam int ROW_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int FL_W  = $clog2(FIRST_DEPTH + 1);
    localparam int SL_W  = $clog2(SECOND_DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W = 33;

    localparam logic [1:0] MODE_FIRST  = 2'd0;
    localparam logic [1:0] MODE_SECOND = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
        logic [6:0]         pair_count;
    } item_t;

    typedef struct packed {
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic               pair_valid;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_SCAN,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic seed_rd;
        logic seed_wr;
        logic scan_init;
        logic scan_issue;
        logic fetch_a;
        logic fetch_b;
        logic emit_pair;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic run_empty;
        logic seed_last;
        logic scan_done;
        logic pair_last;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/core/ksp_ctrl.sv
// Sequencer for the k smallest sum pairs block.
// Depends on ksp_pkg; drives commands into ksp_datapath.
module ksp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic [1:0]      item_mode,
    output logic            item_stall,
    input  ksp_pkg::stat_t  stat,
    output ksp_pkg::cmd_t   cmd
);

    ksp_pkg::state_t state_reg;
    ksp_pkg::state_t state_next;
    logic            fire;

    assign fire       = item_valid && (state_reg == ksp_pkg::ST_IDLE);
    assign item_stall = (state_reg != ksp_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ksp_pkg::ST_IDLE:
            begin
                if (fire && item_mode == ksp_pkg::MODE_RUN)
                begin
                    state_next = stat.run_empty ? ksp_pkg::ST_EMPTY : ksp_pkg::ST_SEED_RD;
                end
            end
            ksp_pkg::ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    state_next = ksp_pkg::ST_IDLE;
                end
            end
            ksp_pkg::ST_SEED_RD:
            begin
                state_next = ksp_pkg::ST_SEED_WR;
            end
            ksp_pkg::ST_SEED_WR:
            begin
                state_next = stat.seed_last ? ksp_pkg::ST_SCAN : ksp_pkg::ST_SEED_RD;
            end
            ksp_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ksp_pkg::ST_FETCH_A;
                end
            end
            ksp_pkg::ST_FETCH_A:
            begin
                state_next = ksp_pkg::ST_FETCH_B;
            end
            ksp_pkg::ST_FETCH_B:
            begin
                state_next = ksp_pkg::ST_EMIT;
            end
            ksp_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.pair_last ? ksp_pkg::ST_IDLE : ksp_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = ksp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ksp_pkg::ST_IDLE:
            begin
                cmd.accept = fire;
            end
            ksp_pkg::ST_EMPTY:
            begin
                cmd.emit_empty = stat.out_free;
            end
            ksp_pkg::ST_SEED_RD:
            begin
                cmd.seed_rd = 1'b1;
            end
            ksp_pkg::ST_SEED_WR:
            begin
                cmd.seed_wr   = 1'b1;
                cmd.scan_init = stat.seed_last;
            end
            ksp_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ksp_pkg::ST_FETCH_A:
            begin
                cmd.fetch_a = 1'b1;
            end
            ksp_pkg::ST_FETCH_B:
            begin
                cmd.fetch_b = 1'b1;
            end
            ksp_pkg::ST_EMIT:
            begin
                cmd.emit_pair = stat.out_free;
                cmd.scan_init = stat.out_free && !stat.pair_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/ksp_datapath.sv
// Arrays, candidate table, minimum scan and result register.
// Depends on ksp_pkg; commanded by ksp_ctrl.
module ksp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ksp_pkg::item_t   item,
    input  ksp_pkg::cmd_t    cmd,
    output ksp_pkg::stat_t   stat,
    output logic             result_valid,
    input  logic             result_stall,
    output ksp_pkg::result_t result
);

    logic [31:0]                      first_mem  [ksp_pkg::FIRST_DEPTH];
    logic [31:0]                      second_mem [ksp_pkg::SECOND_DEPTH];
    logic signed [ksp_pkg::SUM_W-1:0] sum_mem    [ksp_pkg::MAX_PAIRS];
    logic [ksp_pkg::SL_W-1:0]         ptr_mem    [ksp_pkg::MAX_PAIRS];

    logic [ksp_pkg::FL_W-1:0]         len1_reg;
    logic [ksp_pkg::SL_W-1:0]         len2_reg;
    logic [ksp_pkg::CNT_W-1:0]        k_reg;
    logic [ksp_pkg::CNT_W-1:0]        seeds_reg;
    logic [ksp_pkg::CNT_W-1:0]        row_reg;
    logic [ksp_pkg::CNT_W-1:0]        n_reg;
    logic [ksp_pkg::CNT_W-1:0]        active_reg;
    logic                             rd_valid_reg;
    logic                             found_reg;
    logic [ksp_pkg::ROW_W-1:0]        best_row_reg;
    logic [ksp_pkg::SL_W-1:0]         best_ptr_reg;
    logic signed [ksp_pkg::SUM_W-1:0] best_sum_reg;
    logic [ksp_pkg::ROW_W-1:0]        rd_row_reg;
    logic [31:0]                      first_rd_reg;
    logic [31:0]                      second_rd_reg;
    logic signed [ksp_pkg::SUM_W-1:0] sum_rd_reg;
    logic [ksp_pkg::SL_W-1:0]         ptr_rd_reg;
    logic [31:0]                      fv_reg;
    logic [31:0]                      sv_reg;
    logic                             out_valid_reg;
    ksp_pkg::result_t                 out_reg;

    logic [ksp_pkg::CNT_W-1:0]        k_sat;
    logic [ksp_pkg::CNT_W-1:0]        seeds_c;
    logic                             scan_issue_ok;
    logic                             take_row;
    logic [ksp_pkg::SL_W-1:0]         ptr_inc;
    logic                             row_ends;
    logic signed [ksp_pkg::SUM_W-1:0] seed_sum;
    logic signed [ksp_pkg::SUM_W-1:0] next_sum;

    assign k_sat = (item.pair_count > 7'(ksp_pkg::MAX_PAIRS))
                 ? ksp_pkg::CNT_W'(ksp_pkg::MAX_PAIRS)
                 : ksp_pkg::CNT_W'(item.pair_count);
    assign seeds_c = (32'(k_sat) < 32'(len1_reg)) ? k_sat : ksp_pkg::CNT_W'(len1_reg);

    assign scan_issue_ok = cmd.scan_issue && (row_reg < seeds_reg);
    assign take_row = rd_valid_reg && (ptr_rd_reg < len2_reg)
                   && (!found_reg || sum_rd_reg < best_sum_reg);
    assign ptr_inc  = ksp_pkg::SL_W'(best_ptr_reg + 1'b1);
    assign row_ends = (ptr_inc == len2_reg);
    assign seed_sum = $signed({first_rd_reg[31], first_rd_reg})
                    + $signed({second_rd_reg[31], second_rd_reg});
    assign next_sum = $signed({fv_reg[31], fv_reg})
                    + $signed({second_rd_reg[31], second_rd_reg});

    assign stat.run_empty = (len1_reg == '0) || (len2_reg == '0) || (item.pair_count == '0);
    assign stat.seed_last = (ksp_pkg::CNT_W'(row_reg + 1'b1) == seeds_reg);
    assign stat.scan_done = (row_reg == seeds_reg) && !rd_valid_reg;
    assign stat.pair_last = (ksp_pkg::CNT_W'(n_reg + 1'b1) == k_reg)
                         || (active_reg == ksp_pkg::CNT_W'(1) && row_ends);
    assign stat.out_free  = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // array storage and reads
    always_ff @(posedge clk)
    begin
        if (cmd.accept && item.mode == ksp_pkg::MODE_FIRST
            && len1_reg < ksp_pkg::FL_W'(ksp_pkg::FIRST_DEPTH))
        begin
            first_mem[ksp_pkg::FA_W'(len1_reg)] <= item.value;
        end
        if (cmd.accept && item.mode == ksp_pkg::MODE_SECOND
            && len2_reg < ksp_pkg::SL_W'(ksp_pkg::SECOND_DEPTH))
        begin
            second_mem[ksp_pkg::SA_W'(len2_reg)] <= item.value;
        end
        if (cmd.seed_rd)
        begin
            first_rd_reg <= first_mem[ksp_pkg::FA_W'(row_reg)];
        end
        else if (cmd.fetch_a)
        begin
            first_rd_reg <= first_mem[ksp_pkg::FA_W'(best_row_reg)];
        end
        if (cmd.seed_rd)
        begin
            second_rd_reg <= second_mem[ksp_pkg::SA_W'(0)];
        end
        else if (cmd.fetch_a)
        begin
            second_rd_reg <= second_mem[ksp_pkg::SA_W'(best_ptr_reg)];
        end
        else if (cmd.fetch_b)
        begin
            second_rd_reg <= second_mem[ksp_pkg::SA_W'(ptr_inc)];
        end
    end

    // candidate table: one row per seed, current sum and column
    always_ff @(posedge clk)
    begin
        if (cmd.seed_wr)
        begin
            sum_mem[row_reg[ksp_pkg::ROW_W-1:0]] <= seed_sum;
            ptr_mem[row_reg[ksp_pkg::ROW_W-1:0]] <= '0;
        end
        else if (cmd.emit_pair)
        begin
            sum_mem[best_row_reg] <= next_sum;
            ptr_mem[best_row_reg] <= ptr_inc;
        end
        if (scan_issue_ok)
        begin
            sum_rd_reg <= sum_mem[row_reg[ksp_pkg::ROW_W-1:0]];
            ptr_rd_reg <= ptr_mem[row_reg[ksp_pkg::ROW_W-1:0]];
            rd_row_reg <= row_reg[ksp_pkg::ROW_W-1:0];
        end
        if (take_row)
        begin
            best_sum_reg <= sum_rd_reg;
            best_row_reg <= rd_row_reg;
            best_ptr_reg <= ptr_rd_reg;
        end
        if (cmd.fetch_b)
        begin
            fv_reg <= first_rd_reg;
            sv_reg <= second_rd_reg;
        end
        if (cmd.emit_pair)
        begin
            out_reg.first_value  <= fv_reg;
            out_reg.second_value <= sv_reg;
            out_reg.pair_valid   <= 1'b1;
            out_reg.last         <= stat.pair_last;
        end
        else if (cmd.emit_empty)
        begin
            out_reg <= '{first_value: '0, second_value: '0, pair_valid: 1'b0, last: 1'b1};
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg      <= '0;
            len2_reg      <= '0;
            k_reg         <= '0;
            seeds_reg     <= '0;
            row_reg       <= '0;
            n_reg         <= '0;
            active_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                case (item.mode)
                    ksp_pkg::MODE_FIRST:
                    begin
                        if (len1_reg < ksp_pkg::FL_W'(ksp_pkg::FIRST_DEPTH))
                        begin
                            len1_reg <= ksp_pkg::FL_W'(len1_reg + 1'b1);
                        end
                    end
                    ksp_pkg::MODE_SECOND:
                    begin
                        if (len2_reg < ksp_pkg::SL_W'(ksp_pkg::SECOND_DEPTH))
                        begin
                            len2_reg <= ksp_pkg::SL_W'(len2_reg + 1'b1);
                        end
                    end
                    ksp_pkg::MODE_RUN:
                    begin
                        k_reg      <= k_sat;
                        seeds_reg  <= seeds_c;
                        active_reg <= seeds_c;
                        row_reg    <= '0;
                        n_reg      <= '0;
                        if (stat.run_empty)
                        begin
                            len1_reg <= '0;
                            len2_reg <= '0;
                        end
                    end
                    default:
                    begin
                        len1_reg <= len1_reg;
                    end
                endcase
            end

            if (cmd.scan_init)
            begin
                row_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.seed_wr || scan_issue_ok)
            begin
                row_reg <= ksp_pkg::CNT_W'(row_reg + 1'b1);
            end
            if (take_row && !cmd.scan_init)
            begin
                found_reg <= 1'b1;
            end
            rd_valid_reg <= scan_issue_ok;

            if (cmd.emit_pair)
            begin
                n_reg <= ksp_pkg::CNT_W'(n_reg + 1'b1);
                if (row_ends)
                begin
                    active_reg <= ksp_pkg::CNT_W'(active_reg - 1'b1);
                end
                if (stat.pair_last)
                begin
                    len1_reg <= '0;
                    len2_reg <= '0;
                end
            end

            if (cmd.emit_pair || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/k_smallest_sum_pairs.sv
// Top level of the k smallest sum pairs block.
// Depends on ksp_pkg, ksp_ctrl and ksp_datapath.
//
// Append requests are taken in the idle state. A run request with count k
// (saturated at MAX_PAIRS) first seeds one candidate row per element of the
// first array, up to k rows, with a read step and a write step per row, then
// gives each pair: a single-port scan of the candidate table reads one row
// per cycle and settles on the smallest sum, followed by two array reads and
// the result load, which waits while the output is stalled. An empty run
// gives one empty result. Requests are stalled while a run is in progress,
// and the result register lets a new request in while the last result
// waits.
module k_smallest_sum_pairs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ksp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ksp_pkg::result_t result
);

    ksp_pkg::cmd_t  cmd;
    ksp_pkg::stat_t stat;

    ksp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    ksp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: rtl/core/ksp_checker.sv
// Port-level checks for k_smallest_sum_pairs, bound to the top level.
// Depends on ksp_pkg and k_smallest_sum_pairs_macros.svh.
`include "k_smallest_sum_pairs_macros.svh"

module ksp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input ksp_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input ksp_pkg::result_t result
);

    `KSP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `KSP_ASSERT_NOW(a_empty_is_last, clk, rst_n, result_valid && !result.pair_valid, result.last)
    `KSP_ASSERT_NOW(a_empty_is_zero, clk, rst_n, result_valid && !result.pair_valid, result.first_value == 0 && result.second_value == 0)

endmodule

bind k_smallest_sum_pairs ksp_checker u_ksp_checker (.*);
